/* rtl/udac_pkg.sv */
// Package for the unsigned binary to decimal ASCII converter.
// Holds the sizing constants, the payload structs, the state type and the cell control group.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package udac_pkg;

  // Number of value bits that take part in the conversion.
  localparam int unsigned VALUE_WIDTH = 64;
  // Decimal digits needed for the largest value: floor(W * log10(2)) + 1.
  localparam int unsigned NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS + 1);
  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);

  localparam logic [5:0] CHAR_ZERO = 6'd48;
  localparam logic [5:0] CHAR_NUL  = 6'd0;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  capacity;
  } in_item_t;

  typedef struct packed {
    logic [5:0] char_out;
    logic       is_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_e;

  // Control shared by every BCD cell of the chain.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/udac_cell.sv */
// One BCD digit cell of the shift-and-add-3 chain.
// Depends on udac_pkg for the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module udac_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  udac_pkg::cell_ctrl_t  ctrl_i,
  input  logic                  bit_i,
  output logic                  bit_o,
  output logic [3:0]            digit_o
);
  import udac_pkg::*;

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] adjusted;

  // A digit of five or more overflows past nine when doubled, so it is
  // corrected by three before the shift and its top bit moves on.
  assign adjusted = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign bit_o    = adjusted[3];
  assign digit_o  = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.shift) begin
      digit_d = {adjusted[2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/unsigned_to_decimal_ascii_core.sv */
// Unsigned binary to decimal ASCII converter, top level; depends on udac_pkg and udac_cell.
// An accepted item is shifted into the BCD chain bit by bit (ST_CONV), sized (ST_SIZE) and
// emitted from the output register (ST_EMIT), one byte per cycle while the output is not stalled.
// A new item is taken only once the previous one has issued its closing NUL byte; a
// zero-capacity item is accepted and dropped with no output.
// Reset is asynchronous and active low; it clears the control state and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_to_decimal_ascii_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  udac_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output udac_pkg::out_item_t  out_data_o
);
  import udac_pkg::*;

  state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic [7:0]             cap_q, cap_d;
  logic [BIT_CNT_W-1:0]   bits_q, bits_d;
  logic [DIGIT_IDX_W-1:0] idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  cell_ctrl_t             cell_ctrl;
  logic [NUM_DIGITS-1:0]  carry;
  logic [3:0]             digits [NUM_DIGITS];

  logic                   in_xfer;
  logic                   slot_free;
  logic [DIGIT_IDX_W-1:0] ndig;
  logic [7:0]             cap_m1;
  logic [DIGIT_IDX_W-1:0] keep;
  logic [3:0]             sel_digit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Chain of BCD cells; the value enters bit by bit, most significant first.
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    logic cell_in;
    if (k == 0) begin : g_first
      assign cell_in = value_q[VALUE_WIDTH-1];
    end else begin : g_next
      assign cell_in = carry[k-1];
    end
    udac_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .bit_i   (cell_in),
      .bit_o   (carry[k]),
      .digit_o (digits[k])
    );
  end

  // Number of significant digits; zero still has one.
  always_comb begin
    ndig = DIGIT_IDX_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        ndig = DIGIT_IDX_W'(i + 1);
      end
    end
  end

  assign cap_m1    = cap_q - 8'd1;
  assign keep      = ({{(8-DIGIT_IDX_W){1'b0}}, ndig} < cap_m1) ? ndig
                                                               : DIGIT_IDX_W'(cap_m1);
  assign sel_digit = (idx_q != '0) ? digits[idx_q - DIGIT_IDX_W'(1)] : 4'd0;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_data_i.capacity != 8'd0)) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bits_q == BIT_CNT_W'(1)) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && (idx_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    value_d     = value_q;
    cap_d       = cap_q;
    bits_d      = bits_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cell_ctrl   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          value_d         = in_data_i.value[VALUE_WIDTH-1:0];
          cap_d           = in_data_i.capacity;
          bits_d          = BIT_CNT_W'(VALUE_WIDTH);
          cell_ctrl.clear = 1'b1;
        end
      end
      ST_CONV: begin
        cell_ctrl.shift = 1'b1;
        value_d         = {value_q[VALUE_WIDTH-2:0], 1'b0};
        bits_d          = bits_q - BIT_CNT_W'(1);
      end
      ST_SIZE: begin
        idx_d = keep;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (idx_q != '0) begin
            out_d.char_out = CHAR_ZERO + {2'b00, sel_digit};
            out_d.is_last  = 1'b0;
            idx_d          = idx_q - DIGIT_IDX_W'(1);
          end else begin
            out_d.char_out = CHAR_NUL;
            out_d.is_last  = 1'b1;
          end
        end
      end
      default: begin
        cell_ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bits_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bits_q      <= bits_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    cap_q   <= cap_d;
    out_q   <= out_d;
  end

endmodule

`default_nettype wire
